// ===== sv/csvr_pkg.sv =====
// Shared constants, types and a helper function for the CSV cell reader.
package csvr_pkg;

  localparam int LEN_W = 6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] TERM_COMMA  = 2'd0;
  localparam logic [1:0] TERM_LINE   = 2'd1;
  localparam logic [1:0] TERM_QCLOSE = 2'd2;
  localparam logic [1:0] TERM_EOT    = 2'd3;

  // Readout request from the parser to the drain sequencer.
  typedef struct packed {
    logic       go;
    logic       keep;
    logic [1:0] term;
    logic       trunc;
    logic       pend;
    logic [1:0] pend_term;
  } drain_ctl_t;

  // Status of the drain sequencer back to the parser.
  typedef struct packed {
    logic idle;
    logic done;
  } drain_sts_t;

  function automatic logic is_trim(input logic [7:0] b);
    is_trim = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) ||
              (b == CH_LF) || (b == CH_QUOTE);
  endfunction

endpackage

// ===== sv/csvr_if.sv =====
// Valid/ready channel interfaces for text input beats and cell output beats.
interface csvr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

interface csvr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_byte;
  logic       byte_valid;
  logic       last_of_cell;
  logic [1:0] terminator;
  logic       truncated;

  modport source(output valid, output cell_byte, output byte_valid, output last_of_cell,
                 output terminator, output truncated, input ready);
  modport sink(input valid, input cell_byte, input byte_valid, input last_of_cell,
               input terminator, input truncated, output ready);
endinterface

// ===== sv/csvr_regs.sv =====
// APB configuration register file holding the cell length limit.
module csvr_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [csvr_pkg::LEN_W-1:0] max_len
);

  logic sel_len;

  assign sel_len = (paddr[2] == 1'b0);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= '1;
    end else if (psel && penable && pwrite && sel_len) begin
      max_len <= pwdata[csvr_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_len) begin
      prdata[csvr_pkg::LEN_W-1:0] = max_len;
    end
  end

endmodule

// ===== sv/csvr_store.sv =====
// Cell byte store: one write port, one read port with registered read data.
module csvr_store #(
  parameter int CELL_BYTES = 64,
  localparam int AW = $clog2(CELL_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [CELL_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/csvr_parse.sv =====
// Byte parser: tracks the quoting mode, writes cell bytes and hands ended cells to readout.
module csvr_parse #(
  parameter int CELL_BYTES = 64,
  localparam int AW = $clog2(CELL_BYTES)
) (
  input  logic                        clk,
  input  logic                        rst,
  csvr_in_if.sink                     in_ch,
  input  logic [csvr_pkg::LEN_W-1:0]  max_len,
  input  csvr_pkg::drain_sts_t        sts,
  output csvr_pkg::drain_ctl_t        ctl,
  output logic [AW-1:0]               ctl_first,
  output logic [AW-1:0]               ctl_last,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [7:0]                  mem_wdata
);

  localparam int CW = (AW > csvr_pkg::LEN_W) ? AW : csvr_pkg::LEN_W;

  localparam logic [1:0] M_START = 2'd0;
  localparam logic [1:0] M_PLAIN = 2'd1;
  localparam logic [1:0] M_QUOTED = 2'd2;
  localparam logic [1:0] M_QSEEN = 2'd3;

  logic [1:0]    mode;
  logic [AW-1:0] cnt;
  logic [AW-1:0] first;
  logic [AW-1:0] last;
  logic          keep;
  logic          ovf;
  logic          pend_wr;
  logic [7:0]    pend_data;

  logic [7:0]    b;
  logic          acc;
  logic          is_q;
  logic          is_c;
  logic          is_nul;
  logic          is_eol;
  logic          fresh_sel;
  logic [1:0]    eff_mode;
  logic [AW-1:0] base_cnt;
  logic [AW-1:0] base_first;
  logic [AW-1:0] base_last;
  logic          base_keep;
  logic          base_ovf;
  logic          act_put;
  logic          act_end;
  logic [1:0]    act_term;
  logic [1:0]    mode_after;
  logic [CW-1:0] limit;
  logic          full;
  logic          do_write;
  logic          late_wr;

  assign b      = in_ch.in_byte;
  assign acc    = in_ch.valid && in_ch.ready;
  assign is_q   = (b == csvr_pkg::CH_QUOTE);
  assign is_c   = (b == csvr_pkg::CH_COMMA);
  assign is_nul = (b == csvr_pkg::CH_NUL);
  assign is_eol = (b == csvr_pkg::CH_CR) || (b == csvr_pkg::CH_LF);

  // After a closing quote, any byte but a quote or comma ends the cell and
  // is then parsed as the first byte of a new, empty cell.
  assign fresh_sel  = (mode == M_QSEEN) && !is_q && !is_c;
  assign eff_mode   = fresh_sel ? M_START : mode;
  assign base_cnt   = fresh_sel ? '0 : cnt;
  assign base_first = fresh_sel ? '0 : first;
  assign base_last  = fresh_sel ? '0 : last;
  assign base_keep  = fresh_sel ? 1'b0 : keep;
  assign base_ovf   = fresh_sel ? 1'b0 : ovf;

  always_comb begin
    act_put    = 1'b0;
    act_end    = 1'b0;
    act_term   = csvr_pkg::TERM_COMMA;
    mode_after = eff_mode;
    case (eff_mode)
      M_START, M_PLAIN: begin
        if (eff_mode == M_START && is_q) begin
          mode_after = M_QUOTED;
        end else if (is_nul) begin
          act_end  = 1'b1;
          act_term = csvr_pkg::TERM_EOT;
        end else if (is_c) begin
          act_end  = 1'b1;
          act_term = csvr_pkg::TERM_COMMA;
        end else if (is_eol) begin
          act_end  = 1'b1;
          act_term = csvr_pkg::TERM_LINE;
        end else begin
          act_put    = 1'b1;
          mode_after = M_PLAIN;
        end
      end
      M_QUOTED: begin
        if (is_nul) begin
          act_end  = 1'b1;
          act_term = csvr_pkg::TERM_EOT;
        end else if (is_q) begin
          mode_after = M_QSEEN;
        end else begin
          act_put = 1'b1;
        end
      end
      default: begin
        // Only a quote or a comma reaches here.
        if (is_q) begin
          act_put    = 1'b1;
          mode_after = M_QUOTED;
        end else begin
          act_end  = 1'b1;
          act_term = csvr_pkg::TERM_COMMA;
        end
      end
    endcase
  end

  always_comb begin
    limit = CW'(max_len);
    if (limit > CW'(CELL_BYTES - 1)) begin
      limit = CW'(CELL_BYTES - 1);
    end
  end

  assign full     = CW'(base_cnt) >= limit;
  assign do_write = act_put && !full;

  // A byte that opens a new cell while the old one is still being read out
  // is written at address zero only once the readout has finished.
  assign late_wr   = sts.done && pend_wr;
  assign mem_we    = (acc && do_write && !fresh_sel) || late_wr;
  assign mem_waddr = late_wr ? '0 : cnt;
  assign mem_wdata = late_wr ? pend_data : b;

  assign in_ch.ready = sts.idle;

  assign ctl.go        = acc && (fresh_sel || act_end);
  assign ctl.keep      = keep;
  assign ctl.term      = fresh_sel ? csvr_pkg::TERM_QCLOSE : act_term;
  assign ctl.trunc     = ovf;
  assign ctl.pend      = fresh_sel && act_end;
  assign ctl.pend_term = act_term;
  assign ctl_first     = first;
  assign ctl_last      = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_START;
      cnt     <= '0;
      first   <= '0;
      last    <= '0;
      keep    <= 1'b0;
      ovf     <= 1'b0;
      pend_wr <= 1'b0;
    end else begin
      if (late_wr) begin
        pend_wr <= 1'b0;
      end
      if (acc) begin
        if (act_end) begin
          mode  <= M_START;
          cnt   <= '0;
          first <= '0;
          last  <= '0;
          keep  <= 1'b0;
          ovf   <= 1'b0;
        end else begin
          mode  <= mode_after;
          cnt   <= base_cnt + AW'(do_write);
          ovf   <= base_ovf || (act_put && full);
          first <= base_first;
          last  <= base_last;
          keep  <= base_keep;
          if (do_write && !csvr_pkg::is_trim(b)) begin
            if (!base_keep) begin
              first <= base_cnt;
            end
            keep <= 1'b1;
            last <= base_cnt;
          end
          if (fresh_sel && do_write) begin
            pend_wr <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && fresh_sel && do_write) begin
      pend_data <= b;
    end
  end

`ifndef NO_ASSERTIONS
  a_keep_order: assert property (@(posedge clk) disable iff (rst)
    keep |-> (first <= last) && (last < cnt))
    else $error("kept byte range lies outside the stored bytes");
`endif

endmodule

// ===== sv/csvr_drain.sv =====
// Readout sequencer: reads the kept bytes of an ended cell and feeds the output register.
module csvr_drain #(
  parameter int CELL_BYTES = 64,
  localparam int AW = $clog2(CELL_BYTES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  csvr_pkg::drain_ctl_t  ctl,
  input  logic [AW-1:0]         ctl_first,
  input  logic [AW-1:0]         ctl_last,
  output csvr_pkg::drain_sts_t  sts,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [7:0]            mem_rdata,
  csvr_out_if.source            out_ch
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_READ = 2'd1;
  localparam logic [1:0] D_LOAD = 2'd2;

  logic [1:0]    dstate;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] last_idx;
  logic          keep;
  logic [1:0]    term;
  logic          trunc;
  logic          pend;
  logic [1:0]    pend_term;

  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_bv;
  logic          out_last;
  logic [1:0]    out_term;
  logic          out_trunc;

  logic          load;
  logic          cell_last;

  assign load      = (dstate == D_LOAD) && (!out_valid || out_ch.ready);
  assign cell_last = !keep || (rd_ptr == last_idx);

  assign mem_re    = (dstate == D_READ) && keep;
  assign mem_raddr = rd_ptr;

  assign sts.idle = (dstate == D_IDLE);
  assign sts.done = load && cell_last && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate    <= D_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (dstate)
        D_IDLE: begin
          if (ctl.go) begin
            dstate <= D_READ;
          end
        end
        D_READ: begin
          dstate <= D_LOAD;
        end
        D_LOAD: begin
          if (load) begin
            if (cell_last && !pend) begin
              dstate <= D_IDLE;
            end else begin
              dstate <= D_READ;
            end
          end
        end
        default: begin
          dstate <= D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dstate == D_IDLE && ctl.go) begin
      rd_ptr    <= ctl_first;
      last_idx  <= ctl_last;
      keep      <= ctl.keep;
      term      <= ctl.term;
      trunc     <= ctl.trunc;
      pend      <= ctl.pend;
      pend_term <= ctl.pend_term;
    end else if (load) begin
      if (cell_last) begin
        // Second cell from the same byte: always an empty marker.
        keep  <= 1'b0;
        term  <= pend_term;
        trunc <= 1'b0;
        pend  <= 1'b0;
      end else begin
        rd_ptr <= rd_ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= keep ? mem_rdata : 8'h00;
      out_bv    <= keep;
      out_last  <= cell_last;
      out_term  <= term;
      out_trunc <= trunc;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.cell_byte    = out_byte;
  assign out_ch.byte_valid   = out_bv;
  assign out_ch.last_of_cell = out_last;
  assign out_ch.terminator   = out_term;
  assign out_ch.truncated    = out_trunc;

`ifndef NO_ASSERTIONS
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_bv |-> out_last)
    else $error("empty-cell marker is not the last beat of its cell");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (dstate == D_LOAD) && keep |-> rd_ptr <= last_idx)
    else $error("readout pointer ran past the last kept byte");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    sts.done |=> (dstate == D_IDLE))
    else $error("readout finished but sequencer did not return to idle");
`endif

endmodule

// ===== sv/csv_cell_reader_trim.sv =====
// Top level of the CSV cell reader with trimming.
// The block takes one text byte per input beat and splits the text into CSV cells, honoring
// a leading quote, doubled quotes inside quoted cells, and comma, CR/LF and zero-byte
// terminators. When a cell ends, the block emits one output beat per byte of the cell with
// leading and trailing space, tab, CR, LF and quote removed, or a single marker beat with
// byte_valid low when nothing is left. Every beat carries the cell's terminator code and a
// truncated flag that is set when bytes were dropped at the max_cell_length limit (APB
// register at byte address 0, reset 63, capped at CELL_BYTES - 1). A byte that does not end a
// cell is accepted whenever the readout is idle. A byte that ends a cell is accepted and then
// holds off input while the cell is read back from the cell store: the store has one read
// port with registered read data, so each output beat passes through a read state and then a
// load state, and the load waits while the output register is still full. A byte that
// follows a closing quote and also ends the next cell (CR, LF or zero) adds a second, empty
// marker cell to the readout. The output register lets the next input beat be taken while
// the last beat of a cell still waits on the output. No clearing pass is needed after reset.
module csv_cell_reader_trim #(
  parameter int CELL_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  csvr_in_if.sink     in_ch,
  csvr_out_if.source  out_ch
);

  localparam int AW = $clog2(CELL_BYTES);

  logic [csvr_pkg::LEN_W-1:0] max_len;
  csvr_pkg::drain_ctl_t       ctl;
  csvr_pkg::drain_sts_t       sts;
  logic [AW-1:0]              ctl_first;
  logic [AW-1:0]              ctl_last;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [7:0]                 mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [7:0]                 mem_rdata;

  csvr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  // The parser writes the store only while the readout is idle, except for a
  // byte that opens the next cell, which it holds back until the readout ends.
  csvr_parse #(.CELL_BYTES(CELL_BYTES)) u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .max_len   (max_len),
    .sts       (sts),
    .ctl       (ctl),
    .ctl_first (ctl_first),
    .ctl_last  (ctl_last),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  csvr_store #(.CELL_BYTES(CELL_BYTES)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  csvr_drain #(.CELL_BYTES(CELL_BYTES)) u_drain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .ctl_first (ctl_first),
    .ctl_last  (ctl_last),
    .sts       (sts),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_ch    (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("cell store written while a readout is in progress");
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    !(psel && penable && pwrite) |=> $stable(max_len))
    else $error("length limit changed without a register write");
`endif

endmodule

// ===== verif/tb.sv =====
// Testbench for the CSV cell reader: directed, limit and random text against a tracking model.
module tb;

  // The one configuration register sits at byte address 0.
  localparam logic [2:0] REG_MAX_CELL_LENGTH = 3'd0;
  // The predictor's store has the same depth as the block's store.
  localparam int STORE_DEPTH = 64;
  // Idle cycles waited after the last expected beat, to see the block at rest.
  localparam int SETTLE_CYCLES = 16;
  // Hard stop for the whole run, far beyond the slowest correct run.
  localparam int RUN_LIMIT = 10_000_000;

  // Parsing modes of the predictor.
  typedef enum logic [1:0] {
    AT_CELL_START,
    IN_PLAIN,
    IN_QUOTED,
    AFTER_QUOTE
  } text_mode_t;

  // One expected output beat.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic [1:0] term;
    logic       cut;
  } cell_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  csvr_in_if  in_ch ();
  csvr_out_if out_ch ();

  csv_cell_reader_trim u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: a copy of what the block holds for the cell in progress.
  text_mode_t  text_mode = AT_CELL_START;
  logic [7:0]  cell_buf [STORE_DEPTH];
  logic [5:0]  cell_len = '0;
  logic [5:0]  keep_lo = '0;
  logic [5:0]  keep_hi = '0;
  bit          keep_any = 1'b0;
  bit          cut_any = 1'b0;
  logic [5:0]  len_limit = 6'd63;

  // Beats predicted but not yet seen on the output, oldest first.
  cell_beat_t  pending_beats[$];

  int unsigned mismatch_count = 0;
  int unsigned beats_seen = 0;
  int unsigned bytes_taken = 0;

  // Idle chance per cycle, in percent, for the sender and the receiver.
  int unsigned in_idle_pct = 30;
  int unsigned out_idle_pct = 30;
  // While nonzero, the receiver holds ready low; it counts down once per cycle.
  int unsigned rx_hold_left = 0;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Space, tab, CR, LF and quote are stripped from both ends of a cell.
  function automatic bit strips_off(input logic [7:0] b);
    return b == csvr_pkg::CH_SPACE || b == csvr_pkg::CH_TAB || b == csvr_pkg::CH_CR ||
           b == csvr_pkg::CH_LF || b == csvr_pkg::CH_QUOTE;
  endfunction

  // Store one byte of the current cell, or drop it and flag the cell once the limit is hit.
  function automatic void store_byte(input logic [7:0] b);
    if (cell_len >= len_limit) begin
      cut_any = 1'b1;
      return;
    end
    cell_buf[cell_len] = b;
    if (!strips_off(b)) begin
      if (!keep_any) begin
        keep_lo  = cell_len;
        keep_any = 1'b1;
      end
      keep_hi = cell_len;
    end
    cell_len++;
  endfunction

  // End the current cell: queue one beat per kept byte, or the empty marker, and clear the
  // cell state so the next byte starts a new cell.
  function automatic void close_cell(input logic [1:0] term);
    cell_beat_t beat;
    if (keep_any) begin
      for (int i = int'(keep_lo); i <= int'(keep_hi); i++) begin
        beat.data    = cell_buf[i];
        beat.present = 1'b1;
        beat.last    = (i == int'(keep_hi));
        beat.term    = term;
        beat.cut     = cut_any;
        pending_beats.push_back(beat);
      end
    end else begin
      beat.data    = 8'h00;
      beat.present = 1'b0;
      beat.last    = 1'b1;
      beat.term    = term;
      beat.cut     = cut_any;
      pending_beats.push_back(beat);
    end
    text_mode = AT_CELL_START;
    cell_len  = '0;
    keep_lo   = '0;
    keep_hi   = '0;
    keep_any  = 1'b0;
    cut_any   = 1'b0;
  endfunction

  function automatic void plain_step(input logic [7:0] b);
    if (b == csvr_pkg::CH_NUL) begin
      close_cell(csvr_pkg::TERM_EOT);
    end else if (b == csvr_pkg::CH_COMMA) begin
      close_cell(csvr_pkg::TERM_COMMA);
    end else if (b == csvr_pkg::CH_CR || b == csvr_pkg::CH_LF) begin
      close_cell(csvr_pkg::TERM_LINE);
    end else begin
      store_byte(b);
      text_mode = IN_PLAIN;
    end
  endfunction

  // A quote as the first byte of a cell opens quoted mode and is not stored.
  function automatic void start_step(input logic [7:0] b);
    if (b == csvr_pkg::CH_QUOTE) begin
      text_mode = IN_QUOTED;
    end else begin
      plain_step(b);
    end
  endfunction

  // Advance the predictor by one accepted text byte.
  function automatic void track_text_byte(input logic [7:0] b);
    case (text_mode)
      AT_CELL_START: start_step(b);
      IN_PLAIN: plain_step(b);
      IN_QUOTED: begin
        if (b == csvr_pkg::CH_NUL) begin
          close_cell(csvr_pkg::TERM_EOT);
        end else if (b == csvr_pkg::CH_QUOTE) begin
          text_mode = AFTER_QUOTE;
        end else begin
          store_byte(b);
        end
      end
      default: begin
        // A quote right after a quote is a literal quote; a comma ends the cell; anything
        // else ends the cell and is then taken as the first byte of the next one.
        if (b == csvr_pkg::CH_QUOTE) begin
          store_byte(csvr_pkg::CH_QUOTE);
          text_mode = IN_QUOTED;
        end else if (b == csvr_pkg::CH_COMMA) begin
          close_cell(csvr_pkg::TERM_COMMA);
        end else begin
          close_cell(csvr_pkg::TERM_QCLOSE);
          start_step(b);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("MISMATCH beat %0d: %s expected 0x%0h got 0x%0h", beats_seen, what, want, got);
    mismatch_count++;
  endtask

  // The receiver: ready is random, or held low while a hold-off is counting down. A beat
  // moves at an edge where valid and ready were both high just before it.
  always @(posedge clk) begin
    cell_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing expected, cell_byte", 0, 32'(out_ch.cell_byte));
      end else begin
        want = pending_beats.pop_front();
        if (out_ch.cell_byte !== want.data)
          report_mismatch("cell_byte", 32'(want.data), 32'(out_ch.cell_byte));
        if (out_ch.byte_valid !== want.present)
          report_mismatch("byte_valid", 32'(want.present), 32'(out_ch.byte_valid));
        if (out_ch.last_of_cell !== want.last)
          report_mismatch("last_of_cell", 32'(want.last), 32'(out_ch.last_of_cell));
        if (out_ch.terminator !== want.term)
          report_mismatch("terminator", 32'(want.term), 32'(out_ch.terminator));
        if (out_ch.truncated !== want.cut)
          report_mismatch("truncated", 32'(want.cut), 32'(out_ch.truncated));
      end
      beats_seen++;
    end
    out_ch.ready <= !rst && (rx_hold_left == 0) && ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Hold-off counter for the receiver, kept in its own process.
  always @(posedge clk) begin
    if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers. Every task below is entered and left at a rising clock edge.
  // ---------------------------------------------------------------------------------------

  // Offer one byte, with random idle cycles first, and wait until the block takes it. Valid
  // stays high on return so back-to-back bytes need no gap.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    track_text_byte(b);
    bytes_taken++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Wait until every predicted beat has been seen, then let the block settle.
  task automatic wait_drained();
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // End the text with a zero byte so the block is back at cell start, then drain.
  task automatic finish_phase();
    send_byte(csvr_pkg::CH_NUL);
    in_ch.valid <= 1'b0;
    wait_drained();
  endtask

  // APB write of the cell length limit: setup cycle, then access until pready.
  task automatic write_cell_limit(input logic [5:0] lim);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_CELL_LENGTH;
    pwdata  <= {26'd0, lim};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    len_limit = lim;
  endtask

  // Content byte for a random cell. Plain cells never get a comma or line end inside;
  // quoted cells get them often, since that is what quoting is for.
  function automatic logic [7:0] pick_cell_byte(input bit quoted);
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = csvr_pkg::CH_SPACE;
      1: b = csvr_pkg::CH_TAB;
      2: b = csvr_pkg::CH_QUOTE;
      3: begin
        case ($urandom_range(0, 2))
          0: b = csvr_pkg::CH_COMMA;
          1: b = csvr_pkg::CH_CR;
          default: b = csvr_pkg::CH_LF;
        endcase
      end
      default: b = 8'($urandom_range(1, 255));
    endcase
    if (!quoted && (b == csvr_pkg::CH_COMMA || b == csvr_pkg::CH_CR || b == csvr_pkg::CH_LF))
      b = 8'h5F;
    return b;
  endfunction

  // One well-formed cell with random content and a random ending. Most cells are short; one
  // in ten is 20 to 70 bytes long, so it can run past the largest limit and truncation shows up at every setting.
  task automatic send_random_cell();
    int unsigned n_bytes;
    bit          quoted;
    logic [7:0]  b;
    n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 6);
    quoted  = ($urandom_range(0, 2) == 0);
    if (quoted) send_byte(csvr_pkg::CH_QUOTE);
    repeat (n_bytes) begin
      b = pick_cell_byte(quoted);
      send_byte(b);
      // A quote inside a quoted cell is written twice.
      if (quoted && b == csvr_pkg::CH_QUOTE) send_byte(csvr_pkg::CH_QUOTE);
    end
    if (quoted) send_byte(csvr_pkg::CH_QUOTE);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_byte(csvr_pkg::CH_COMMA);
      4: send_byte(csvr_pkg::CH_CR);
      5: send_byte(csvr_pkg::CH_LF);
      6: begin
        send_byte(csvr_pkg::CH_CR);
        send_byte(csvr_pkg::CH_LF);
      end
      7: send_byte(csvr_pkg::CH_NUL);
      default: begin
        // A quoted cell may be followed directly by the next cell.
        if (!quoted) send_byte(csvr_pkg::CH_COMMA);
      end
    endcase
  endtask

  // Arbitrary bytes over the full range, so every bit of in_byte toggles.
  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_text(input int unsigned n_items);
    int unsigned first;
    first = bytes_taken;
    while (bytes_taken - first < n_items) begin
      if ($urandom_range(0, 99) < 25) send_noise();
      else send_random_cell();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Directed text at the reset limit: doubled quote, closing quote then another byte, CR LF
  // pair, closing quote then end of text, extreme byte values with trimming, an empty cell.
  task automatic test_directed();
    send_text("\"a\"\"b\",");
    send_text("\"x\"y");
    send_byte(csvr_pkg::CH_CR);
    send_byte(csvr_pkg::CH_LF);
    send_text("\"q\"");
    send_byte(csvr_pkg::CH_NUL);
    send_byte(csvr_pkg::CH_SPACE);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(csvr_pkg::CH_TAB);
    send_byte(csvr_pkg::CH_COMMA);
    send_byte(csvr_pkg::CH_COMMA);
    finish_phase();
  endtask

  // Small limits, including zero: long cells get cut, and a doubled quote that lands past
  // the limit is dropped and flags the cell.
  task automatic test_cell_limits();
    logic [5:0] lims [3] = '{6'd0, 6'd1, 6'd2};
    foreach (lims[i]) begin
      write_cell_limit(lims[i]);
      send_text("\"ab\"\"c\",");
      send_text("  hello  ,");
      send_text("\"\",x,");
      finish_phase();
    end
  endtask

  task automatic test_random(input int unsigned n_items, input logic [5:0] lim,
                             input int unsigned idle_pct);
    write_cell_limit(lim);
    in_idle_pct  = idle_pct;
    out_idle_pct = idle_pct;
    send_random_text(n_items);
    finish_phase();
    in_idle_pct  = 30;
    out_idle_pct = 30;
  endtask

  // The receiver stops for a long stretch while the sender keeps offering text, so the block
  // fills and stalls its input. Later the sender stops until everything has come out.
  task automatic test_backpressure();
    write_cell_limit(6'd63);
    rx_hold_left <= 400;
    send_random_text(40);
    in_ch.valid <= 1'b0;
    wait_drained();
    send_random_text(30);
    finish_phase();
  endtask

  // ---------------------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------------------

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_cell_limits();
    test_random(100, 6'd63, 30);
    // A stretch with no idling on either side.
    test_random(60, 6'd7, 0);
    test_random(50, 6'($urandom_range(3, 62)), 30);
    test_backpressure();
    test_random(40, 6'd63, 30);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/csvr_pkg.sv
sv/csvr_if.sv
sv/csvr_regs.sv
sv/csvr_store.sv
sv/csvr_parse.sv
sv/csvr_drain.sv
sv/csv_cell_reader_trim.sv
verif/tb.sv
